@@ rtl/hpve_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hpve_pkg;
   localparam int MaxSamples = 256;
   localparam int CntW = $clog2(MaxSamples) + 1;
   localparam int IdxW = 8;
   localparam int TempW = 15;
   localparam int SumW = 25;
   localparam int GainW = 16;
   localparam int VelW = 20;
   localparam int StatW = 2;
   localparam int QDepth = 2;

   localparam logic [1:0] RegStart = 2'd0;
   localparam logic [1:0] RegEnd = 2'd1;
   localparam logic [1:0] RegGain = 2'd2;

   localparam logic [StatW-1:0] StOk = 2'd0;
   localparam logic [StatW-1:0] StInvalid = 2'd1;
   localparam logic [StatW-1:0] StClamp = 2'd2;
   localparam logic [StatW-1:0] StBadIdx = 2'd3;

   localparam logic [VelW-1:0] VelInvalid = 20'd999999;
   localparam logic [15:0] Ln2Q16 = 16'd45426;

   typedef struct packed {
      logic signed [SumW-1:0] sum_ub;
      logic signed [SumW-1:0] sum_db;
      logic signed [SumW-1:0] sum_ua;
      logic signed [SumW-1:0] sum_da;
      logic [CntW-1:0]        size;
      logic [IdxW-1:0]        start_idx;
      logic [IdxW-1:0]        stop_idx;
      logic [GainW-1:0]       gain;
   } job_type;
endpackage
`default_nettype wire

@@ rtl/hpve_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hpve_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [15:0]                  csr_data,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [hpve_pkg::TempW-1:0]   temp_up,
   input  wire logic [hpve_pkg::TempW-1:0]   temp_down,
   input  wire logic                         last,
   output logic                              push,
   output hpve_pkg::job_type                 job,
   input  wire logic                         q_full
);
   import hpve_pkg::*;

   logic [IdxW-1:0] start_ff, stop_ff;
   logic [GainW-1:0] gain_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic signed [SumW-1:0] ub_ff, db_ff, ua_ff, da_ff;
   logic signed [SumW-1:0] ub_in, db_in, ua_in, da_in;
   logic accept, keep;
   logic [IdxW-1:0] idx;
   logic signed [SumW-1:0] tu, td;

   assign csr_ready = 1'b1;
   assign in_ready = !q_full;
   assign accept = in_valid && in_ready;
   assign keep = !count_ff[CntW-1];
   assign idx = count_ff[IdxW-1:0];
   assign tu = SumW'($signed(temp_up));
   assign td = SumW'($signed(temp_down));

   always_comb begin
      ub_in = ub_ff;
      db_in = db_ff;
      ua_in = ua_ff;
      da_in = da_ff;
      count_in = count_ff;
      if (accept && keep) begin
         if (idx < start_ff) begin
            ub_in = ub_ff + tu;
            db_in = db_ff + td;
         end else if (idx > stop_ff) begin
            ua_in = ua_ff + tu;
            da_in = da_ff + td;
         end
         count_in = count_ff + 1'b1;
      end
   end

   assign push = accept && last;
   always_comb begin
      job.sum_ub = ub_in;
      job.sum_db = db_in;
      job.sum_ua = ua_in;
      job.sum_da = da_in;
      job.size = count_in;
      job.start_idx = start_ff;
      job.stop_idx = stop_ff;
      job.gain = gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'd10;
         stop_ff <= 8'd30;
         gain_ff <= 16'd3840;
         count_ff <= '0;
         ub_ff <= '0;
         db_ff <= '0;
         ua_ff <= '0;
         da_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               RegStart: start_ff <= csr_data[IdxW-1:0];
               RegEnd: stop_ff <= csr_data[IdxW-1:0];
               RegGain: gain_ff <= csr_data;
               default: ;
            endcase
         end
         if (push) begin
            count_ff <= '0;
            ub_ff <= '0;
            db_ff <= '0;
            ua_ff <= '0;
            da_ff <= '0;
         end else begin
            count_ff <= count_in;
            ub_ff <= ub_in;
            db_ff <= db_in;
            ua_ff <= ua_in;
            da_ff <= da_in;
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/hpve_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hpve_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hpve_pkg::job_type  wr_job,
   output logic                    full,
   output logic                    not_empty,
   input  wire logic               pop,
   output hpve_pkg::job_type       rd_job
);
   import hpve_pkg::*;

   job_type slot_ff [QDepth];
   logic [$clog2(QDepth)-1:0] wp_ff, rp_ff;
   logic [$clog2(QDepth):0] cnt_ff;

   assign full = cnt_ff == ($clog2(QDepth)+1)'(QDepth);
   assign not_empty = cnt_ff != '0;
   assign rd_job = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         case ({push, pop})
            2'b10: cnt_ff <= cnt_ff + 1'b1;
            2'b01: cnt_ff <= cnt_ff - 1'b1;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/hpve_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hpve_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_not_empty,
   output logic                             pop,
   input  wire hpve_pkg::job_type           q_job,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [hpve_pkg::VelW-1:0]        velocity_centi,
   output logic [hpve_pkg::StatW-1:0]       status
);
   import hpve_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_PROD = 12'b000000000010,
      S_DIFF = 12'b000000000100,
      S_CHK  = 12'b000000001000,
      S_NORM = 12'b000000010000,
      S_SQR  = 12'b000000100000,
      S_SQB  = 12'b000001000000,
      S_LOGD = 12'b000010000000,
      S_V1   = 12'b000100000000,
      S_V2   = 12'b001000000000,
      S_V3   = 12'b010000000000,
      S_DONE = 12'b100000000000
   } state_type;

   state_type state_ff;
   job_type job_ff;
   logic [1:0] pc_ff;
   logic signed [34:0] prod_ff [4];
   logic signed [35:0] n_ff, d_ff;
   logic [35:0] norm_ff;
   logic [5:0] e_ff;
   logic [31:0] m_ff;
   logic [63:0] sq_ff;
   logic [15:0] frac_ff;
   logic [3:0] it_ff;
   logic which_ff;
   logic [21:0] logn_ff;
   logic [21:0] lval_ff;
   logic [37:0] p_ff;
   logic [34:0] lo_ff, hi_ff;
   logic [VelW-1:0] vel_ff;
   logic [StatW-1:0] st_ff;
   logic out_valid_ff;
   logic [VelW-1:0] rvel_ff;
   logic [StatW-1:0] rst_ff;

   logic signed [SumW-1:0] psum;
   logic [CntW-1:0] pfac, na;
   logic [32:0] sq_top;
   logic [22:0] ldiff;
   logic [54:0] total;
   logic bad, empty;
   logic load;

   assign na = job_ff.size - CntW'(job_ff.stop_idx) - 1'b1;
   assign bad = (CntW'(job_ff.start_idx) >= job_ff.size) ||
                (CntW'(job_ff.stop_idx) >= job_ff.size) ||
                (job_ff.start_idx > job_ff.stop_idx);
   assign empty = (job_ff.start_idx == '0) || (na == '0);
   assign sq_top = sq_ff[63:31];
   assign ldiff = {1'b0, logn_ff} - {1'b0, e_ff, frac_ff};
   assign total = 55'(hi_ff) * 55'(2**19) + 55'(lo_ff) + 55'(2**39);

   always_comb begin
      case (pc_ff)
         2'd0: begin psum = job_ff.sum_da; pfac = CntW'(job_ff.start_idx); end
         2'd1: begin psum = job_ff.sum_db; pfac = na; end
         2'd2: begin psum = job_ff.sum_ua; pfac = CntW'(job_ff.start_idx); end
         default: begin psum = job_ff.sum_ub; pfac = na; end
      endcase
   end

   assign pop = (state_ff == S_IDLE) && q_not_empty;
   assign load = (state_ff == S_DONE) && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign velocity_centi = rvel_ff;
   assign status = rst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
         rvel_ff <= (st_ff == StOk) ? VelW'(total[54:40]) : vel_ff;
         rst_ff <= st_ff;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_not_empty) begin
                  job_ff <= q_job;
                  pc_ff <= '0;
                  state_ff <= S_PROD;
               end
            end
            S_PROD: begin
               prod_ff[pc_ff] <= 35'(psum * $signed({1'b0, pfac}));
               pc_ff <= pc_ff + 1'b1;
               if (pc_ff == 2'd3) state_ff <= S_DIFF;
            end
            S_DIFF: begin
               n_ff <= 36'(prod_ff[0]) - 36'(prod_ff[1]);
               d_ff <= 36'(prod_ff[2]) - 36'(prod_ff[3]);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (bad) begin
                  vel_ff <= '0;
                  st_ff <= StBadIdx;
                  state_ff <= S_DONE;
               end else if (empty || n_ff == '0 || d_ff == '0 || (n_ff[35] != d_ff[35])) begin
                  vel_ff <= VelInvalid;
                  st_ff <= StInvalid;
                  state_ff <= S_DONE;
               end else begin
                  norm_ff <= n_ff[35] ? 36'(-n_ff) : n_ff;
                  e_ff <= 6'd35;
                  which_ff <= 1'b0;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (norm_ff[35]) begin
                  m_ff <= norm_ff[35:4];
                  frac_ff <= '0;
                  it_ff <= '0;
                  state_ff <= S_SQR;
               end else begin
                  norm_ff <= {norm_ff[34:0], 1'b0};
                  e_ff <= e_ff - 1'b1;
               end
            end
            S_SQR: begin
               sq_ff <= 64'(m_ff) * 64'(m_ff);
               state_ff <= S_SQB;
            end
            S_SQB: begin
               frac_ff <= {frac_ff[14:0], sq_top[32]};
               m_ff <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
               it_ff <= it_ff + 1'b1;
               state_ff <= (it_ff == 4'd15) ? S_LOGD : S_SQR;
            end
            S_LOGD: begin
               if (!which_ff) begin
                  logn_ff <= {e_ff, frac_ff};
                  norm_ff <= d_ff[35] ? 36'(-d_ff) : d_ff;
                  e_ff <= 6'd35;
                  which_ff <= 1'b1;
                  state_ff <= S_NORM;
               end else if (ldiff[22]) begin
                  vel_ff <= '0;
                  st_ff <= StClamp;
                  state_ff <= S_DONE;
               end else begin
                  lval_ff <= ldiff[21:0];
                  state_ff <= S_V1;
               end
            end
            S_V1: begin
               p_ff <= 38'(job_ff.gain) * 38'(lval_ff);
               state_ff <= S_V2;
            end
            S_V2: begin
               lo_ff <= 35'(p_ff[18:0]) * 35'(Ln2Q16);
               state_ff <= S_V3;
            end
            S_V3: begin
               hi_ff <= 35'(p_ff[37:19]) * 35'(Ln2Q16);
               state_ff <= S_DONE;
               st_ff <= StOk;
               vel_ff <= '0;
            end
            S_DONE: begin
               if (load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/heat_pulse_velocity_estimator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Heat ratio velocity estimator. Each sample item is taken in one cycle. The
// item marked tlast closes the run and hands a job to a two-deep queue; the
// back end then handles one job at a time: a bit-serial normalize and 16
// square steps for each of its two logarithms, and it takes the next job from
// the queue only after the last result has gone to the output register. Input
// stalls only while both queue slots are full.
module heat_pulse_velocity_estimator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // temp_up[14:0], temp_down[29:15], zero pad
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // velocity_centi[19:0], status[21:20], zero pad
);
   import hpve_pkg::*;

   logic push, q_full, q_ne, pop;
   job_type wjob, rjob;
   logic [VelW-1:0] vel;
   logic [StatW-1:0] st;

   hpve_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .temp_up(req_tdata[14:0]), .temp_down(req_tdata[29:15]), .last(req_tlast),
      .push, .job(wjob), .q_full
   );

   hpve_queue u_queue (
      .clock, .reset, .push, .wr_job(wjob), .full(q_full), .not_empty(q_ne),
      .pop, .rd_job(rjob)
   );

   hpve_back u_back (
      .clock, .reset, .q_not_empty(q_ne), .pop, .q_job(rjob),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .velocity_centi(vel), .status(st)
   );

   assign rsp_tdata = {2'b00, st, vel};
endmodule
`default_nettype wire

@@ rtl/hpve_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hpve_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   import hpve_pkg::*;

   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:20] == StBadIdx |-> rsp_tdata[19:0] == '0)
      else $error("bad index result must carry zero velocity");
   a_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:20] == StInvalid |-> rsp_tdata[19:0] == VelInvalid)
      else $error("invalid result must carry 999999");
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:20] == StClamp |-> rsp_tdata[19:0] == '0)
      else $error("clamped result must carry zero velocity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind heat_pulse_velocity_estimator_top hpve_checker u_hpve_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire
